// ===== rtl/core/step_sequencer_tick_macros.svh =====
// Assertion macros for the step sequencer.
// Used by step_sequencer_tick.sv; no other dependencies.
`ifndef STEP_SEQUENCER_TICK_MACROS_SVH
`define STEP_SEQUENCER_TICK_MACROS_SVH

// same-cycle implication
`define STSQ_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STSQ_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/stsq_pkg.sv =====
// Shared types, codes and constants for the step sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package stsq_pkg;

    localparam int MAX_STEPS_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 32;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int TEMPO_W   = 16;
    localparam int RATE_W    = 32;
    localparam int PROD_W    = TEMPO_W + RATE_W;
    localparam int SEQ_LEN_W = 7;
    localparam int TRACK_W   = 4;
    localparam int NOTE_W    = 7;
    localparam int LENGTH_W  = 16;
    localparam int STEP_NUM_W = 6;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_NUMBER     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_NOTE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_VELOCITY = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LENGTH   = 3'd5;

    // register reset values
    localparam logic [SEQ_LEN_W-1:0] RST_SEQUENCE_LENGTH  = 7'd16;
    localparam logic [RATE_W-1:0]    RST_RATE_SCALE       = 32'd6108397;
    localparam logic [TRACK_W-1:0]   RST_TRACK_NUMBER     = 4'd0;
    localparam logic [NOTE_W-1:0]    RST_DEFAULT_NOTE     = 7'd60;
    localparam logic [NOTE_W-1:0]    RST_DEFAULT_VELOCITY = 7'd100;
    localparam logic [LENGTH_W-1:0]  RST_DEFAULT_LENGTH   = 16'd256;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] KIND_STEP  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // pending-event bits, in emission order
    localparam int EVB_END_RUN  = 0;
    localparam int EVB_STEP     = 1;
    localparam int EVB_END_SWAP = 2;
    localparam int EVB_START    = 3;
    localparam int EVB_N        = 4;

    typedef struct packed {
        logic                op;
        logic [TEMPO_W-1:0]  tempo;
        logic [5:0]          entry_index;
        logic                entry_on;
        logic [NOTE_W-1:0]   entry_note;
        logic                entry_note_given;
        logic [NOTE_W-1:0]   entry_velocity;
        logic                entry_velocity_given;
        logic [LENGTH_W-1:0] entry_length;
        logic                entry_length_given;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            event_kind;
        logic [TRACK_W-1:0]    event_track;
        logic [STEP_NUM_W-1:0] step_number;
        logic                  step_active;
        logic                  first_tick_flag;
        logic [NOTE_W-1:0]     note_out;
        logic [NOTE_W-1:0]     velocity_out;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic                on;
        logic [NOTE_W-1:0]   note;
        logic                note_given;
        logic [NOTE_W-1:0]   velocity;
        logic                velocity_given;
        logic [LENGTH_W-1:0] length;
        logic                length_given;
    } step_entry_t;

    localparam int ENTRY_W = $bits(step_entry_t);

    typedef struct packed {
        logic [EVB_N-1:0]      mask;
        logic [STEP_NUM_W-1:0] step_number;
        logic                  active;
        logic                  first;
        logic [NOTE_W-1:0]     note;
        logic [NOTE_W-1:0]     velocity;
    } evt_set_t;

endpackage

`default_nettype wire

// ===== rtl/core/stsq_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// Defaults taken from stsq_pkg.
`default_nettype none

module stsq_ram #(
    parameter int WIDTH = stsq_pkg::ENTRY_W,
    parameter int DEPTH = stsq_pkg::MAX_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stsq_evt_out.sv =====
// Output buffer: holds the events of one tick and issues them one per transfer.
// Depends on stsq_pkg.
`default_nettype none

module stsq_evt_out (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  stsq_pkg::evt_set_t            set,
    input  logic [stsq_pkg::TRACK_W-1:0]  track,
    output logic                          free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output stsq_pkg::out_item_t           out_data
);

    import stsq_pkg::*;

    logic [EVB_N-1:0] mask_reg;
    logic [EVB_N-1:0] mask_next;
    evt_set_t         set_reg;
    logic [EVB_N-1:0] rest;
    logic             last;

    assign rest      = mask_reg & (mask_reg - EVB_N'(1));
    assign last      = (rest == '0);
    assign out_valid = |mask_reg;
    assign free      = !out_valid || (out_ready && last);

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = set.mask;
        end
        else if (out_valid && out_ready)
        begin
            mask_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            set_reg <= set;
        end
    end

    always_comb
    begin
        out_data             = '0;
        out_data.event_track = track;
        out_data.last        = last;
        if (mask_reg[EVB_END_RUN])
        begin
            out_data.event_kind = KIND_END;
        end
        else if (mask_reg[EVB_STEP])
        begin
            out_data.event_kind      = KIND_STEP;
            out_data.step_number     = set_reg.step_number;
            out_data.step_active     = set_reg.active;
            out_data.first_tick_flag = set_reg.first;
        end
        else if (mask_reg[EVB_END_SWAP])
        begin
            out_data.event_kind = KIND_END;
        end
        else if (mask_reg[EVB_START])
        begin
            out_data.event_kind   = KIND_START;
            out_data.note_out     = set_reg.note;
            out_data.velocity_out = set_reg.velocity;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/step_sequencer_tick.sv =====
// Step sequencer top level: configuration, tick pipeline, step table.
// Depends on stsq_pkg, stsq_ram, stsq_evt_out and the assertion macros header.
`default_nettype none
`include "step_sequencer_tick_macros.svh"

// Each transfer in is either a sample tick or a step table write. Items pass through an
// input register that feeds the tempo x rate multiply, a position stage (wrap, step
// detect, step table read) and a note stage that loads an event buffer. An item may enter
// every cycle unless the event buffer holds back the pipeline; the output port issues one
// event per cycle while out_ready is high, so a tick that yields events holds the buffer
// until its last event is taken; silent ticks and writes load none. The step table reads
// as all steps off from reset on, through a valid bit per entry, with no clearing pass.
// Configuration is to be written only while the block is idle; no check enforces it.
module step_sequencer_tick #(
    parameter int MAX_STEPS     = stsq_pkg::MAX_STEPS_DEF,
    parameter int FRACTION_BITS = stsq_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [stsq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stsq_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  stsq_pkg::in_item_t              in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output stsq_pkg::out_item_t             out_data
);

    import stsq_pkg::*;

    localparam int IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
    localparam int INT_W = $clog2(MAX_STEPS + 1);
    localparam int POS_W = IDX_W + FRACTION_BITS;
    localparam int SUM_W = INT_W + FRACTION_BITS;
    localparam int REM_W = FRACTION_BITS + 8;
    localparam int CMP_W = (INT_W > SEQ_LEN_W) ? INT_W : SEQ_LEN_W;
    localparam int WIX_W = (IDX_W > 6) ? IDX_W + 1 : 7;

    // configuration
    logic [SEQ_LEN_W-1:0] seq_len_reg;
    logic [RATE_W-1:0]    rate_scale_reg;
    logic [TRACK_W-1:0]   track_reg;
    logic [NOTE_W-1:0]    def_note_reg;
    logic [NOTE_W-1:0]    def_vel_reg;
    logic [LENGTH_W-1:0]  def_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg    <= RST_SEQUENCE_LENGTH;
            rate_scale_reg <= RST_RATE_SCALE;
            track_reg      <= RST_TRACK_NUMBER;
            def_note_reg   <= RST_DEFAULT_NOTE;
            def_vel_reg    <= RST_DEFAULT_VELOCITY;
            def_len_reg    <= RST_DEFAULT_LENGTH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_SEQUENCE_LENGTH:  seq_len_reg    <= cfg_data[SEQ_LEN_W-1:0];
                REG_RATE_SCALE:       rate_scale_reg <= cfg_data[RATE_W-1:0];
                REG_TRACK_NUMBER:     track_reg      <= cfg_data[TRACK_W-1:0];
                REG_DEFAULT_NOTE:     def_note_reg   <= cfg_data[NOTE_W-1:0];
                REG_DEFAULT_VELOCITY: def_vel_reg    <= cfg_data[NOTE_W-1:0];
                REG_DEFAULT_LENGTH:   def_len_reg    <= cfg_data[LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s1_ready, s2_ready, s3_ready;
    logic s2_adv, s3_adv, buf_free;

    assign s3_adv   = s3_valid_reg && buf_free;
    assign s3_ready = !s3_valid_reg || buf_free;
    assign s2_adv   = s2_valid_reg && s3_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // stage 1: input register, multiply
    in_item_t              s1_reg;
    logic [PROD_W-1:0]     product;

    assign product = s1_reg.tempo * rate_scale_reg;

    // stage 2: position
    in_item_t                 s2_reg;
    logic [FRACTION_BITS-1:0] s2_inc_reg;
    logic [POS_W-1:0]         position_reg;
    logic                     first_pending_reg;
    logic [MAX_STEPS-1:0]     entry_valid_reg;

    logic                     s2_tick;
    logic [INT_W-1:0]         len;
    logic [SUM_W-1:0]         limit;
    logic [SUM_W:0]           limit2;
    logic [SUM_W-1:0]         sum;
    logic                     wrapped;
    logic                     too_far;
    logic [SUM_W-1:0]         pos_sum;
    logic [POS_W-1:0]         pos_new;
    logic [IDX_W-1:0]         prev_step;
    logic [IDX_W-1:0]         cur_step;
    logic                     step_change;
    logic                     idx_ok;
    logic [IDX_W-1:0]         waddr;
    logic                     ram_we;
    logic                     ram_re;
    step_entry_t              wentry;
    logic [ENTRY_W-1:0]       ram_rdata;

    assign s2_tick = (s2_reg.op == OP_TICK);

    always_comb
    begin
        if (seq_len_reg == '0)
        begin
            len = INT_W'(1);
        end
        else if (CMP_W'(seq_len_reg) > CMP_W'(MAX_STEPS))
        begin
            len = INT_W'(MAX_STEPS);
        end
        else
        begin
            len = INT_W'(seq_len_reg);
        end
    end

    assign limit   = {len, {FRACTION_BITS{1'b0}}};
    assign limit2  = {len, {(FRACTION_BITS + 1){1'b0}}};
    assign sum     = SUM_W'(position_reg) + SUM_W'(s2_inc_reg);
    assign wrapped = (sum >= limit);
    assign too_far = ({1'b0, sum} >= limit2);

    always_comb
    begin
        if (!wrapped)
        begin
            pos_sum = sum;
        end
        else if (too_far)
        begin
            pos_sum = '0;
        end
        else
        begin
            pos_sum = sum - limit;
        end
    end

    assign pos_new     = POS_W'(pos_sum);
    assign prev_step   = position_reg[POS_W-1 -: IDX_W];
    assign cur_step    = pos_new[POS_W-1 -: IDX_W];
    assign step_change = (cur_step != prev_step) || wrapped || first_pending_reg;

    assign idx_ok = (WIX_W'(s2_reg.entry_index) < WIX_W'(MAX_STEPS));
    assign waddr  = IDX_W'(s2_reg.entry_index);
    assign ram_we = s2_adv && !s2_tick && idx_ok;
    assign ram_re = s2_adv && s2_tick;

    assign wentry.on             = s2_reg.entry_on;
    assign wentry.note           = s2_reg.entry_note;
    assign wentry.note_given     = s2_reg.entry_note_given;
    assign wentry.velocity       = s2_reg.entry_velocity;
    assign wentry.velocity_given = s2_reg.entry_velocity_given;
    assign wentry.length         = s2_reg.entry_length;
    assign wentry.length_given   = s2_reg.entry_length_given;

    stsq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wentry),
        .re    (ram_re),
        .raddr (cur_step),
        .rdata (ram_rdata)
    );

    // stage 3: note tracking
    logic                     s3_tick_reg;
    logic [FRACTION_BITS-1:0] s3_inc_reg;
    logic [IDX_W-1:0]         s3_step_reg;
    logic                     s3_change_reg;
    logic                     s3_first_reg;
    logic                     s3_entry_ok_reg;
    logic                     note_held_reg;
    logic                     note_held_next;
    logic [REM_W-1:0]         remaining_reg;
    logic [REM_W-1:0]         remaining_next;

    step_entry_t              entry;
    logic [REM_W-1:0]         inc_ext;
    logic                     end_run;
    logic                     held_after;
    logic                     trigger;
    logic [LENGTH_W-1:0]      note_len;
    evt_set_t                 evt_set;

    assign entry      = s3_entry_ok_reg ? step_entry_t'(ram_rdata) : '0;
    assign inc_ext    = REM_W'(s3_inc_reg);
    assign end_run    = note_held_reg && (remaining_reg <= inc_ext);
    assign held_after = note_held_reg && !end_run;
    assign trigger    = s3_change_reg && entry.on;
    assign note_len   = entry.length_given ? entry.length : def_len_reg;

    always_comb
    begin
        evt_set                        = '0;
        evt_set.step_number            = STEP_NUM_W'(s3_step_reg);
        evt_set.active                 = entry.on;
        evt_set.first                  = s3_first_reg;
        evt_set.note                   = entry.note_given ? entry.note : def_note_reg;
        evt_set.velocity               = entry.velocity_given ? entry.velocity : def_vel_reg;
        if (s3_tick_reg)
        begin
            evt_set.mask[EVB_END_RUN]  = end_run;
            evt_set.mask[EVB_STEP]     = s3_change_reg;
            evt_set.mask[EVB_END_SWAP] = trigger && held_after;
            evt_set.mask[EVB_START]    = trigger;
        end
    end

    always_comb
    begin
        note_held_next = note_held_reg;
        remaining_next = remaining_reg;
        if (s3_adv && s3_tick_reg)
        begin
            if (trigger)
            begin
                note_held_next = 1'b1;
                remaining_next = REM_W'({note_len, {(FRACTION_BITS - 8){1'b0}}});
            end
            else
            begin
                note_held_next = held_after;
                remaining_next = remaining_reg - inc_ext;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            s3_valid_reg      <= 1'b0;
            position_reg      <= '0;
            first_pending_reg <= 1'b1;
            entry_valid_reg   <= '0;
            note_held_reg     <= 1'b0;
            remaining_reg     <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s2_adv && s2_tick)
            begin
                position_reg      <= pos_new;
                first_pending_reg <= 1'b0;
            end
            if (ram_we)
            begin
                entry_valid_reg[waddr] <= 1'b1;
            end
            note_held_reg <= note_held_next;
            remaining_reg <= remaining_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_reg <= in_data;
        end
        if (s1_valid_reg && s2_ready)
        begin
            s2_reg     <= s1_reg;
            s2_inc_reg <= product[PROD_W-1 -: FRACTION_BITS];
        end
        if (s2_adv)
        begin
            s3_tick_reg     <= s2_tick;
            s3_inc_reg      <= s2_inc_reg;
            s3_step_reg     <= cur_step;
            s3_change_reg   <= step_change;
            s3_first_reg    <= first_pending_reg;
            s3_entry_ok_reg <= entry_valid_reg[cur_step];
        end
    end

    stsq_evt_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (s3_adv),
        .set       (evt_set),
        .track     (track_reg),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    `STSQ_ASSERT_NOW(a_start_after_step, clk, rst_n,
                     s3_adv && evt_set.mask[EVB_START], evt_set.mask[EVB_STEP],
                     "note start without step change")
    `STSQ_ASSERT_NOW(a_single_end, clk, rst_n, s3_adv,
                     !(evt_set.mask[EVB_END_RUN] && evt_set.mask[EVB_END_SWAP]),
                     "two note ends in one tick")
    `STSQ_ASSERT_NEXT(a_start_holds_note, clk, rst_n,
                      s3_adv && evt_set.mask[EVB_START], note_held_reg,
                      "started note not held")
    `STSQ_ASSERT_NOW(a_first_clear_on_tick, clk, rst_n,
                     $fell(first_pending_reg), $past(s2_adv && s2_tick),
                     "first tick flag cleared without a tick")

endmodule

`default_nettype wire
